/* sv/nrch_pkg.sv */
// shared types and constants for the nearest ray circle hit unit
package nrch_pkg;

	localparam int COORD_BITS = 16;

	typedef struct packed {
		logic signed [15:0] center_x;
		logic signed [15:0] center_y;
		logic [5:0]         circle_index;
		logic               circle_active;
		logic               last_circle;
	} in_beat_t;

	typedef struct packed {
		logic               hit_found;
		logic signed [15:0] ghost_x;
		logic signed [15:0] ghost_y;
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic [15:0]        hit_distance;
		logic               deflect_shown;
	} out_beat_t;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_DIR_X    = 3'd2;
	localparam logic [2:0] REG_DIR_Y    = 3'd3;
	localparam logic [2:0] REG_RADIUS   = 3'd4;
	localparam logic [2:0] REG_ORIG_IDX = 3'd5;

	localparam logic [16:0] BEST_NONE = 17'h1FFFF;
	localparam logic [16:0] T_MAX     = 17'h1FFFE;
	localparam int          CROSS_EPS = 2684;

	// datapath step commands
	localparam logic [3:0] OP_NONE   = 4'd0;
	localparam logic [3:0] OP_LOAD   = 4'd1;
	localparam logic [3:0] OP_DOT    = 4'd2;
	localparam logic [3:0] OP_DISC   = 4'd3;
	localparam logic [3:0] OP_SQRT   = 4'd4;
	localparam logic [3:0] OP_ROOT   = 4'd5;
	localparam logic [3:0] OP_GHOST  = 4'd6;
	localparam logic [3:0] OP_FWD    = 4'd7;
	localparam logic [3:0] OP_KEEP   = 4'd8;
	localparam logic [3:0] OP_NORM   = 4'd9;
	localparam logic [3:0] OP_DIV    = 4'd10;
	localparam logic [3:0] OP_CROSS  = 4'd11;
	localparam logic [3:0] OP_EMIT   = 4'd12;
	localparam logic [3:0] OP_DOT2   = 4'd13;
	localparam logic [3:0] OP_DISC2  = 4'd14;

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic test;      // circle takes part
		logic no_root;   // negative discriminant or no forward root
		logic not_better;
		logic sqrt_done;
		logic div_done;
		logic have_hit;
	} stat_t;

endpackage

/* sv/nearest_ray_circle_hit_unit.sv */
// top level of the nearest ray circle hit unit
//  channel  | signals                         | beat
//  in       | in_valid, in_ready, in_data     | one circle center
//  out      | out_valid, out_ready, out_data  | one result after a last circle
//  cfg      | cfg_we, cfg_index, cfg_data     | one register write
// a tested circle runs the dot, discriminant, bit-serial square root, root, ghost, forward and keep steps
// a negative discriminant ends a tested circle at the root step; a skipped circle is only loaded
// a last circle adds the finish and emit steps, and with a hit also the two serial divides
// one circle in flight at a time; a waiting result stalls only the next result
// reset restores register defaults and clears the search
module nearest_ray_circle_hit_unit #(
	parameter int MAX_CIRCLES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  nrch_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output nrch_pkg::out_beat_t out_data
);
	import nrch_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	nrch_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_last(in_data.last_circle),
		.out_valid, .out_ready, .stat, .cmd
	);

	nrch_datapath #(.MAX_CIRCLES(MAX_CIRCLES)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_beat(in_data),
		.cmd, .stat, .result(out_data)
	);
endmodule

/* sv/nrch_datapath.sv */
// datapath: registers, multipliers, shared sqrt and divide units
module nrch_datapath #(
	parameter int MAX_CIRCLES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  nrch_pkg::in_beat_t  in_beat,
	input  nrch_pkg::cmd_t      cmd,
	output nrch_pkg::stat_t     stat,
	output nrch_pkg::out_beat_t result
);
	import nrch_pkg::*;

	localparam int CMAX = (1 << (COORD_BITS - 1)) - 1;

	logic signed [15:0] org_x_q, org_y_q, dir_x_q, dir_y_q;
	logic [11:0]        radius_q;
	logic [5:0]         orig_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q    <= '0;
			org_y_q    <= '0;
			dir_x_q    <= 16'sd16384;
			dir_y_q    <= '0;
			radius_q   <= '0;
			orig_idx_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: org_x_q    <= cfg_data;
				REG_ORIGIN_Y: org_y_q    <= cfg_data;
				REG_DIR_X:    dir_x_q    <= cfg_data;
				REG_DIR_Y:    dir_y_q    <= cfg_data;
				REG_RADIUS:   radius_q   <= cfg_data[11:0];
				REG_ORIG_IDX: orig_idx_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// working registers
	logic signed [15:0] cx_q, cy_q;
	logic signed [16:0] ox_q, oy_q;
	logic signed [34:0] acc_q;       // dot products, cross
	logic signed [19:0] dot4_q;
	logic signed [35:0] c_q;
	logic signed [36:0] disc_q;
	logic signed [34:0] t_q;
	logic signed [15:0] gx_q, gy_q;
	logic [16:0]        best_q;
	logic signed [15:0] bgx_q, bgy_q, btx_q, bty_q;
	logic               have_q;
	logic               no_root_q, worse_q, fwd_ok_q;
	logic signed [16:0] offx_q, offy_q;
	logic signed [15:0] nx_q, ny_q;
	logic               div_y_q;

	// index check
	logic idx_in;
	always_comb begin
		if (MAX_CIRCLES >= 64) idx_in = 1'b1;
		else idx_in = ({1'b0, in_beat.circle_index} < 7'(MAX_CIRCLES));
	end
	assign stat.test = in_beat.circle_active && (in_beat.circle_index != orig_idx_q)
		&& idx_in && (radius_q != '0);

	function automatic logic signed [34:0] rnd14(input logic signed [34:0] v);
		logic signed [34:0] a;
		a = v + 35'sd8192;
		return a >>> 14;
	endfunction

	function automatic logic signed [15:0] sat_c(input logic signed [35:0] v);
		if (v > 36'sd0 + CMAX) return 16'(CMAX);
		if (v < -36'sd1 - CMAX) return 16'(-CMAX - 1);
		return v[15:0];
	endfunction

	// sqrt unit: one result bit per cycle
	logic [35:0] sq_rem_q, sq_root_q, sq_bit_q;
	logic        sq_busy_q;
	logic [35:0] sq_try;
	assign sq_try = sq_root_q + sq_bit_q;

	// divider unit: restoring, one bit per cycle
	logic [30:0] dv_num_q;
	logic [30:0] dv_quo_q;
	logic [13:0] dv_rem_q;
	logic [4:0]  dv_cnt_q;
	logic        dv_busy_q;
	logic [14:0] dv_sh;
	logic [12:0] den;
	assign den   = {radius_q, 1'b0};
	assign dv_sh = {dv_rem_q, dv_num_q[30]};

	assign stat.sqrt_done = !sq_busy_q;
	assign stat.div_done  = !dv_busy_q;
	assign stat.no_root   = no_root_q;
	assign stat.not_better = worse_q || !fwd_ok_q || no_root_q;
	assign stat.have_hit  = have_q;

	logic signed [34:0] root_a, root_b;
	logic [16:0]        tc;
	assign root_a = 35'(dot4_q) - 35'($signed({1'b0, sq_root_q[33:0]}));
	assign root_b = 35'(dot4_q) + 35'($signed({1'b0, sq_root_q[33:0]}));
	assign tc = (t_q > 35'sd131070) ? T_MAX : t_q[16:0];

	logic signed [15:0] nq;
	logic signed [30:0] qs;
	assign qs = div_y_q ? (offy_q < 0 ? -31'(dv_quo_q) : 31'(dv_quo_q))
		: (offx_q < 0 ? -31'(dv_quo_q) : 31'(dv_quo_q));
	assign nq = (qs > 31'sd16384) ? 16'sd16384 : (qs < -31'sd16384) ? -16'sd16384 : qs[15:0];

	logic signed [33:0] cross_a;
	assign cross_a = (acc_q < 0) ? 34'(-acc_q) : 34'(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q    <= BEST_NONE;
			have_q    <= 1'b0;
			sq_busy_q <= 1'b0;
			dv_busy_q <= 1'b0;
			bgx_q <= '0; bgy_q <= '0; btx_q <= '0; bty_q <= '0;
		end else begin
			if (sq_busy_q) begin
				if (sq_bit_q == '0) sq_busy_q <= 1'b0;
				else begin
					if (sq_rem_q >= sq_try) begin
						sq_rem_q  <= sq_rem_q - sq_try;
						sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
					end else sq_root_q <= sq_root_q >> 1;
					sq_bit_q <= sq_bit_q >> 2;
				end
			end
			if (dv_busy_q) begin
				dv_num_q <= dv_num_q << 1;
				if (dv_sh >= {2'b0, den}) begin
					dv_rem_q <= 14'(dv_sh - {2'b0, den});
					dv_quo_q <= {dv_quo_q[29:0], 1'b1};
				end else begin
					dv_rem_q <= dv_sh[13:0];
					dv_quo_q <= {dv_quo_q[29:0], 1'b0};
				end
				dv_cnt_q <= dv_cnt_q - 5'd1;
				if (dv_cnt_q == 5'd0) dv_busy_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_LOAD: begin
					cx_q <= in_beat.center_x;
					cy_q <= in_beat.center_y;
					ox_q <= 17'(in_beat.center_x) - 17'(org_x_q);
					oy_q <= 17'(in_beat.center_y) - 17'(org_y_q);
				end
				OP_DOT: acc_q <= 35'(dir_x_q * ox_q);
				OP_DOT2: begin
					dot4_q <= 20'(rnd14(acc_q + 35'(dir_y_q * oy_q)));
					c_q    <= 36'(ox_q * ox_q);
				end
				OP_DISC: c_q <= c_q + 36'(oy_q * oy_q) - 36'($signed({1'b0, den}) * $signed({1'b0, den}));
				OP_DISC2: begin
					disc_q    <= 37'(dot4_q * dot4_q) - 37'(c_q);
				end
				OP_SQRT: begin
					no_root_q <= disc_q < 0;
					sq_rem_q  <= disc_q[35:0];
					sq_root_q <= '0;
					sq_bit_q  <= 36'h4_0000_0000;
					sq_busy_q <= !(disc_q < 0);
				end
				OP_ROOT: begin
					if (root_a > 0) t_q <= root_a;
					else if (root_b > 0) t_q <= root_b;
					else no_root_q <= 1'b1;
				end
				OP_GHOST: begin
					worse_q <= tc >= best_q;
					gx_q <= sat_c(36'(org_x_q) + 36'(rnd14(35'(dir_x_q * 20'(t_q)))));
					gy_q <= sat_c(36'(org_y_q) + 36'(rnd14(35'(dir_y_q * 20'(t_q)))));
				end
				OP_FWD: begin
					fwd_ok_q <= (35'((17'(cx_q) - 17'(gx_q)) * dir_x_q)
						+ 35'((17'(cy_q) - 17'(gy_q)) * dir_y_q)) > 35'sd2;
				end
				OP_KEEP: begin
					best_q <= tc;
					bgx_q <= gx_q; bgy_q <= gy_q;
					btx_q <= cx_q; bty_q <= cy_q;
					have_q <= 1'b1;
				end
				OP_NORM: begin
					offx_q <= 17'(btx_q) - 17'(bgx_q);
					offy_q <= 17'(bty_q) - 17'(bgy_q);
					div_y_q <= 1'b0;
					dv_num_q <= 31'({(17'(btx_q) - 17'(bgx_q) < 0) ? 17'(bgx_q) - 17'(btx_q)
						: 17'(btx_q) - 17'(bgx_q), 14'b0}) + 31'(den >> 1);
					dv_quo_q <= '0; dv_rem_q <= '0; dv_cnt_q <= 5'd30; dv_busy_q <= 1'b1;
				end
				OP_DIV: begin
					nx_q <= nq;
					div_y_q <= 1'b1;
					dv_num_q <= 31'({offy_q < 0 ? -offy_q : offy_q, 14'b0}) + 31'(den >> 1);
					dv_quo_q <= '0; dv_rem_q <= '0; dv_cnt_q <= 5'd30; dv_busy_q <= 1'b1;
				end
				OP_CROSS: begin
					ny_q  <= nq;
					acc_q <= 35'(dir_x_q * nq) - 35'(dir_y_q * nx_q);
				end
				OP_EMIT: begin
					result.hit_found     <= have_q;
					result.ghost_x       <= have_q ? bgx_q : '0;
					result.ghost_y       <= have_q ? bgy_q : '0;
					result.target_x      <= have_q ? btx_q : '0;
					result.target_y      <= have_q ? bty_q : '0;
					result.normal_x      <= have_q ? nx_q : '0;
					result.normal_y      <= have_q ? ny_q : '0;
					result.hit_distance  <= have_q ? (best_q[16] ? 16'hFFFF : best_q[15:0]) : '0;
					result.deflect_shown <= have_q && (cross_a > 34'(CROSS_EPS));
					best_q <= BEST_NONE; have_q <= 1'b0;
					bgx_q <= '0; bgy_q <= '0; btx_q <= '0; bty_q <= '0;
				end
				default: ;
			endcase
		end
	end

	logic unused;
	assign unused = ^{sq_rem_q[35]};
endmodule

/* sv/nrch_ctrl.sv */
// controller state machine sequencing one beat through the datapath
module nrch_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            in_last,
	output logic            out_valid,
	input  logic            out_ready,
	input  nrch_pkg::stat_t stat,
	output nrch_pkg::cmd_t  cmd
);
	import nrch_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0, S_DOT = 4'd1, S_DOT2 = 4'd2, S_DISC = 4'd3,
		S_DISC2 = 4'd4, S_SQRT = 4'd5, S_SQW = 4'd6, S_ROOT = 4'd7, S_GHOST = 4'd8,
		S_FWD = 4'd9, S_KEEP = 4'd10, S_FIN = 4'd11, S_DIVX = 4'd12, S_DIVY = 4'd13,
		S_CROSS = 4'd14, S_EMIT = 4'd15;

	logic [3:0] state_q;
	logic       last_q, ovalid_q;
	logic       emit_go;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ovalid_q;
	// result register is free or its beat leaves at this edge
	assign emit_go   = (state_q == S_EMIT) && (!ovalid_q || out_ready);

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE:  cmd.op = (in_valid && in_ready) ? OP_LOAD : OP_NONE;
			S_DOT:   cmd.op = OP_DOT;
			S_DOT2:  cmd.op = OP_DOT2;
			S_DISC:  cmd.op = OP_DISC;
			S_DISC2: cmd.op = OP_DISC2;
			S_SQRT:  cmd.op = OP_SQRT;
			S_ROOT:  cmd.op = stat.no_root ? OP_NONE : OP_ROOT;
			S_GHOST: cmd.op = OP_GHOST;
			S_FWD:   cmd.op = OP_FWD;
			S_KEEP:  cmd.op = stat.not_better ? OP_NONE : OP_KEEP;
			S_FIN:   cmd.op = stat.have_hit ? OP_NORM : OP_NONE;
			S_DIVY:  cmd.op = stat.div_done ? OP_DIV : OP_NONE;
			S_CROSS: cmd.op = stat.div_done ? OP_CROSS : OP_NONE;
			S_EMIT:  cmd.op = emit_go ? OP_EMIT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			last_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (emit_go) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					last_q  <= in_last;
					state_q <= stat.test ? S_DOT : (in_last ? S_FIN : S_IDLE);
				end
				S_DOT:   state_q <= S_DOT2;
				S_DOT2:  state_q <= S_DISC;
				S_DISC:  state_q <= S_DISC2;
				S_DISC2: state_q <= S_SQRT;
				S_SQRT:  state_q <= S_SQW;
				S_SQW:   if (stat.sqrt_done) state_q <= S_ROOT;
				S_ROOT:  state_q <= stat.no_root ? (last_q ? S_FIN : S_IDLE) : S_GHOST;
				S_GHOST: state_q <= S_FWD;
				S_FWD:   state_q <= S_KEEP;
				S_KEEP:  state_q <= last_q ? S_FIN : S_IDLE;
				S_FIN:   state_q <= stat.have_hit ? S_DIVX : S_EMIT;
				S_DIVX:  state_q <= S_DIVY;
				S_DIVY:  if (stat.div_done) state_q <= S_CROSS;
				S_CROSS: if (stat.div_done) state_q <= S_EMIT;
				S_EMIT:  if (emit_go) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
